FILE: sv/kgc_pkg.sv
package kgc_pkg;

  localparam int MAX_KEYS   = 24;
  localparam int HIST_DEPTH = 5;
  localparam int KEY_W      = 5;
  localparam int CNT_W      = 8;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  localparam logic [1:0] REG_KEY_COUNT  = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_LONG_WAIT  = 2'd2;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_PRESS_SHORT,
    ST_PRESS_LONG,
    ST_WAIT_SHORT,
    ST_WAIT_LONG
  } key_st_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CLICK,
    ACT_DOUBLE_CLICK,
    ACT_HOLD,
    ACT_DOUBLE_HOLD
  } act_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_FLUSH
  } seq_st_t;

  typedef struct packed {
    logic [CNT_W-1:0]           press;
    logic [CNT_W-1:0]           rel;
    key_st_t [HIST_DEPTH-1:0]   hist;
  } key_rec_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    act_t             act;
  } result_t;

endpackage

FILE: sv/kgc_cell.sv
module kgc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  kgc_pkg::key_rec_t rec_in,
  output kgc_pkg::key_rec_t rec_out
);
  import kgc_pkg::*;

  key_rec_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else if (shift_en) begin
      rec_r <= rec_in;
    end
  end

  assign rec_out = rec_r;

endmodule

FILE: sv/kgc_update.sv
module kgc_update (
  input  kgc_pkg::key_rec_t        rec_in,
  input  logic                     enable,
  input  logic                     pressed,
  input  logic [kgc_pkg::CNT_W-1:0] long_press,
  input  logic [kgc_pkg::CNT_W-1:0] long_wait,
  output kgc_pkg::key_rec_t        rec_out,
  output kgc_pkg::act_t            act
);
  import kgc_pkg::*;

  function automatic act_t classify(input key_st_t [HIST_DEPTH-1:0] h);
    act_t a;
    a = ACT_NONE;
    if (h[0] == ST_WAIT_SHORT && h[1] == ST_PRESS_SHORT && h[2] == ST_WAIT_SHORT &&
        h[3] == ST_PRESS_SHORT && h[4] == ST_WAIT_LONG) begin
      a = ACT_DOUBLE_CLICK;
    end
    if (h[0] == ST_WAIT_LONG && h[1] == ST_WAIT_SHORT && h[2] == ST_PRESS_SHORT &&
        h[3] == ST_WAIT_LONG) begin
      a = ACT_CLICK;
    end
    if (h[0] == ST_PRESS_LONG && h[1] == ST_PRESS_SHORT && h[2] == ST_WAIT_SHORT &&
        h[3] == ST_PRESS_SHORT && h[4] == ST_WAIT_LONG) begin
      a = ACT_DOUBLE_HOLD;
    end
    if (h[0] == ST_PRESS_LONG && h[1] == ST_PRESS_SHORT && h[2] == ST_WAIT_LONG) begin
      a = ACT_HOLD;
    end
    return a;
  endfunction

  key_rec_t rec;
  key_st_t  st;

  always_comb begin
    rec = rec_in;
    st  = ST_NONE;
    act = ACT_NONE;
    if (pressed) begin
      rec.rel = '0;
      if (rec_in.press != CNT_MAX) begin
        rec.press = rec_in.press + 1'b1;
      end
      st = (rec.press >= long_press) ? ST_PRESS_LONG : ST_PRESS_SHORT;
    end else begin
      rec.press = '0;
      if (rec_in.rel != CNT_MAX) begin
        rec.rel = rec_in.rel + 1'b1;
      end
      st = (rec.rel >= long_wait) ? ST_WAIT_LONG : ST_WAIT_SHORT;
    end
    if (rec_in.hist[0] != st) begin
      rec.hist = {rec_in.hist[HIST_DEPTH-2:0], st};
      act = classify(rec.hist);
    end
    if (!enable) begin
      rec = rec_in;
      act = ACT_NONE;
    end
    rec_out = rec;
  end

endmodule

FILE: sv/keypad_gesture_classifier.sv
// a scan goes from request to the next in_ready through SEQ_RUN, which rotates the
// ring of key cells one key per cycle while not stalled, then SEQ_FLUSH, which flushes
// the final result; the rotation stalls while a new gesture meets a pending result and
// the result register waits on out_ready, and the flush likewise waits on out_ready
// each result waits in pend_r for the next gesture or the flush; the last has out_last
// reset: key_count 8, both long thresholds 10, all counters and histories cleared
module keypad_gesture_classifier (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_scan_byte_0,
  input  logic [7:0]                  in_scan_byte_1,
  input  logic [7:0]                  in_scan_byte_2,
  input  logic [7:0]                  in_scan_byte_3,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kgc_pkg::KEY_W-1:0]   out_key_index,
  output logic [2:0]                  out_action,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kgc_pkg::ADDR_W-1:0]  paddr,
  input  logic [kgc_pkg::DATA_W-1:0]  pwdata,
  output logic [kgc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import kgc_pkg::*;

  logic [KEY_W-1:0] key_count_r;
  logic [CNT_W-1:0] long_press_r;
  logic [CNT_W-1:0] long_wait_r;

  seq_st_t state_r, state_nxt;
  logic [KEY_W-1:0] k_r;
  logic [3:0][7:0]  scan_r;
  result_t          pend_r;
  logic             pend_v_r;

  logic             out_valid_r;
  result_t          out_res_r;
  logic             out_last_r;

  key_rec_t ring [MAX_KEYS];
  key_rec_t upd_rec;
  act_t     upd_act;
  logic     step;
  logic     push;
  result_t  push_res;
  logic     push_last;
  logic     push_ok;
  logic     key_en;
  logic     pressed;
  logic [KEY_W-1:0] n_eff;
  logic [2:0] bit_pos;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r  <= KEY_W'(8);
      long_press_r <= CNT_W'(10);
      long_wait_r  <= CNT_W'(10);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_KEY_COUNT:  key_count_r  <= pwdata[KEY_W-1:0];
        REG_LONG_PRESS: long_press_r <= pwdata[CNT_W-1:0];
        REG_LONG_WAIT:  long_wait_r  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KEY_COUNT:  prdata = DATA_W'(key_count_r);
      REG_LONG_PRESS: prdata = DATA_W'(long_press_r);
      REG_LONG_WAIT:  prdata = DATA_W'(long_wait_r);
      default:        prdata = '0;
    endcase
  end

  // ring of key cells
  genvar gi;
  generate
    for (gi = 0; gi < MAX_KEYS; gi++) begin : g_cell
      if (gi == MAX_KEYS - 1) begin : g_tail
        kgc_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (step),
          .rec_in   (upd_rec),
          .rec_out  (ring[gi])
        );
      end else begin : g_body
        kgc_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (step),
          .rec_in   (ring[gi+1]),
          .rec_out  (ring[gi])
        );
      end
    end
  endgenerate

  assign n_eff   = (key_count_r > KEY_W'(MAX_KEYS)) ? KEY_W'(MAX_KEYS) : key_count_r;
  assign key_en  = (state_r == SEQ_RUN) && (k_r < n_eff);
  assign bit_pos = {k_r[2], k_r[4:3]};
  assign pressed = scan_r[k_r[1:0]][bit_pos];

  kgc_update u_update (
    .rec_in     (ring[0]),
    .enable     (key_en),
    .pressed    (pressed),
    .long_press (long_press_r),
    .long_wait  (long_wait_r),
    .rec_out    (upd_rec),
    .act        (upd_act)
  );

  // sequencer
  assign push_ok  = !out_valid_r || out_ready;
  assign in_ready = (state_r == SEQ_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step      = 1'b0;
    push      = 1'b0;
    push_res  = pend_r;
    push_last = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          state_nxt = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        step = !(upd_act != ACT_NONE && pend_v_r && !push_ok);
        push = step && upd_act != ACT_NONE && pend_v_r;
        if (step && k_r == KEY_W'(MAX_KEYS - 1)) begin
          state_nxt = SEQ_FLUSH;
        end
      end
      SEQ_FLUSH: begin
        push_last = 1'b1;
        if (!pend_v_r) begin
          push_res = '{key: '0, act: ACT_NONE};
        end
        if (push_ok) begin
          push      = 1'b1;
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= '0;
      pend_v_r <= 1'b0;
    end else begin
      if (state_r == SEQ_IDLE) begin
        k_r <= '0;
      end else if (step) begin
        k_r <= k_r + 1'b1;
      end
      if (state_r == SEQ_FLUSH && push_ok) begin
        pend_v_r <= 1'b0;
      end else if (step && upd_act != ACT_NONE) begin
        pend_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      scan_r <= {in_scan_byte_3, in_scan_byte_2, in_scan_byte_1, in_scan_byte_0};
    end
    if (step && upd_act != ACT_NONE) begin
      pend_r <= '{key: k_r, act: upd_act};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r  <= push_res;
      out_last_r <= push_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_index = out_res_r.key;
  assign out_action    = out_res_r.act;
  assign out_last      = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_v_r)
    else $error("pending result left over in idle");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer did not start on request");

  a_key_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SEQ_RUN |-> k_r < KEY_W'(MAX_KEYS))
    else $error("key index past the ring");

  a_none_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_NONE) |-> (out_last && out_key_index == '0))
    else $error("none result not final or nonzero key");

endmodule

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kgc_pkg::*;

  typedef struct {
    logic [KEY_W-1:0] key;
    act_t             act;
    logic             last;
  } gesture_t;

  typedef enum int {MIX_NONE, MIX_SENDER, MIX_RECEIVER, MIX_BOTH} idle_mix_t;

  class gesture_scoreboard;
    key_st_t          hist [MAX_KEYS][HIST_DEPTH];
    logic [CNT_W-1:0] press_cnt [MAX_KEYS];
    logic [CNT_W-1:0] rel_cnt [MAX_KEYS];
    logic [KEY_W-1:0] key_count;
    logic [CNT_W-1:0] long_press;
    logic [CNT_W-1:0] long_wait;
    gesture_t         pending [$];
    int               mismatches;
    int               scans;
    int               results;
    int               act_seen [5];

    function new();
      key_count  = 5'd8;
      long_press = 8'd10;
      long_wait  = 8'd10;
      for (int k = 0; k < MAX_KEYS; k++) begin
        press_cnt[k] = '0;
        rel_cnt[k]   = '0;
        for (int i = 0; i < HIST_DEPTH; i++) hist[k][i] = ST_NONE;
      end
      mismatches = 0;
      scans      = 0;
      results    = 0;
      foreach (act_seen[i]) act_seen[i] = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_KEY_COUNT:  key_count  = v[KEY_W-1:0];
        REG_LONG_PRESS: long_press = v[CNT_W-1:0];
        REG_LONG_WAIT:  long_wait  = v[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function act_t match_gesture(int k);
      act_t a;
      a = ACT_NONE;
      if (hist[k][0] == ST_WAIT_SHORT && hist[k][1] == ST_PRESS_SHORT &&
          hist[k][2] == ST_WAIT_SHORT && hist[k][3] == ST_PRESS_SHORT &&
          hist[k][4] == ST_WAIT_LONG)
        a = ACT_DOUBLE_CLICK;
      if (hist[k][0] == ST_WAIT_LONG && hist[k][1] == ST_WAIT_SHORT &&
          hist[k][2] == ST_PRESS_SHORT && hist[k][3] == ST_WAIT_LONG)
        a = ACT_CLICK;
      if (hist[k][0] == ST_PRESS_LONG && hist[k][1] == ST_PRESS_SHORT &&
          hist[k][2] == ST_WAIT_SHORT && hist[k][3] == ST_PRESS_SHORT &&
          hist[k][4] == ST_WAIT_LONG)
        a = ACT_DOUBLE_HOLD;
      if (hist[k][0] == ST_PRESS_LONG && hist[k][1] == ST_PRESS_SHORT &&
          hist[k][2] == ST_WAIT_LONG)
        a = ACT_HOLD;
      return a;
    endfunction

    function void note_scan(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
      logic [7:0] scan [4];
      int       n;
      int       bus;
      int       bno;
      logic     hit;
      key_st_t  st;
      act_t     a;
      gesture_t held;
      bit       have_held;
      scan[0] = b0;
      scan[1] = b1;
      scan[2] = b2;
      scan[3] = b3;
      scans++;
      have_held = 0;
      n = (key_count > MAX_KEYS) ? MAX_KEYS : key_count;
      for (int k = 0; k < n; k++) begin
        bus = k / 8;
        bno = k % 8;
        hit = scan[bno & 3][(bno < 4) ? bus : bus + 4];
        if (hit) begin
          rel_cnt[k] = '0;
          if (press_cnt[k] != CNT_MAX) press_cnt[k]++;
          st = (press_cnt[k] >= long_press) ? ST_PRESS_LONG : ST_PRESS_SHORT;
        end else begin
          press_cnt[k] = '0;
          if (rel_cnt[k] != CNT_MAX) rel_cnt[k]++;
          st = (rel_cnt[k] >= long_wait) ? ST_WAIT_LONG : ST_WAIT_SHORT;
        end
        if (hist[k][0] != st) begin
          for (int i = HIST_DEPTH - 1; i > 0; i--) hist[k][i] = hist[k][i-1];
          hist[k][0] = st;
          a = match_gesture(k);
          if (a != ACT_NONE) begin
            if (have_held) pending.push_back(held);
            held.key  = KEY_W'(k);
            held.act  = a;
            held.last = 1'b0;
            have_held = 1;
          end
        end
      end
      if (!have_held) begin
        held.key = '0;
        held.act = ACT_NONE;
      end
      held.last = 1'b1;
      pending.push_back(held);
    endfunction

    function void check_result(logic [KEY_W-1:0] key, logic [2:0] act, logic last);
      gesture_t g;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result key %0d action %0d last %0b", key, act, last));
        return;
      end
      g = pending.pop_front();
      results++;
      act_seen[g.act]++;
      if (key !== g.key || act !== g.act || last !== g.last)
        flag($sformatf("expected key %0d action %0d last %0b, got key %0d action %0d last %0b",
                       g.key, g.act, g.last, key, act, last));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_scan_byte_0;
  logic [7:0]           in_scan_byte_1;
  logic [7:0]           in_scan_byte_2;
  logic [7:0]           in_scan_byte_3;
  logic                 out_valid;
  logic                 out_ready;
  logic [KEY_W-1:0]     out_key_index;
  logic [2:0]           out_action;
  logic                 out_last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  gesture_scoreboard sb = new();

  int   send_idle_pct;
  int   recv_stall_pct;
  int   cur_press;
  int   cur_wait;
  logic key_level [MAX_KEYS];
  int   run_left [MAX_KEYS];

  localparam logic [17:0] DIRECTED_SEQ = 18'b001011001001010011;

  keypad_gesture_classifier uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_scan_byte_0 (in_scan_byte_0),
    .in_scan_byte_1 (in_scan_byte_1),
    .in_scan_byte_2 (in_scan_byte_2),
    .in_scan_byte_3 (in_scan_byte_3),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_index  (out_key_index),
    .out_action     (out_action),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[keypad_gesture_classifier] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_scan(in_scan_byte_0, in_scan_byte_1, in_scan_byte_2, in_scan_byte_3);
      if (out_valid && out_ready)
        sb.check_result(out_key_index, out_action, out_last);
    end
  end

  task automatic send_scan(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_scan_byte_0 = b0;
    in_scan_byte_1 = b1;
    in_scan_byte_2 = b2;
    in_scan_byte_3 = b3;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_level(input logic pressed);
    send_scan({8{pressed}}, {8{pressed}}, {8{pressed}}, {8{pressed}});
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic apb(input logic wr, input logic [1:0] idx, input logic [DATA_W-1:0] wdata,
                     output logic [DATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) sb.write_reg(idx, wdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input int kc, input int lp, input int lw);
    logic [DATA_W-1:0] rd;
    wait_drained();
    repeat (30) @(negedge clk);
    apb(1'b1, REG_KEY_COUNT, DATA_W'(kc), rd);
    apb(1'b1, REG_LONG_PRESS, DATA_W'(lp), rd);
    apb(1'b1, REG_LONG_WAIT, DATA_W'(lw), rd);
    apb(1'b0, REG_KEY_COUNT, '0, rd);
    if (rd !== DATA_W'(kc & 31)) sb.flag($sformatf("key_count read %0d, wrote %0d", rd, kc));
    apb(1'b0, REG_LONG_PRESS, '0, rd);
    if (rd !== DATA_W'(lp & 255)) sb.flag($sformatf("long press read %0d, wrote %0d", rd, lp));
    apb(1'b0, REG_LONG_WAIT, '0, rd);
    if (rd !== DATA_W'(lw & 255)) sb.flag($sformatf("long wait read %0d, wrote %0d", rd, lw));
    cur_press = lp;
    cur_wait  = lw;
  endtask

  // short, long or arbitrary run around the active threshold
  function automatic int run_length(logic pressed, bit wide);
    int t;
    int r;
    t = pressed ? cur_press : cur_wait;
    if (t < 1) t = 1;
    if (wide) return $urandom_range(300, 1);
    r = $urandom_range(99);
    if (r < 45) return (t > 1) ? $urandom_range(t - 1, 1) : 1;
    if (r < 85) return $urandom_range(t + 2, t);
    return $urandom_range(2 * t + 3, 1);
  endfunction

  task automatic gesture_scan(input bit wide, input bit noise);
    logic [7:0] b [4];
    int         bus;
    int         bno;
    foreach (b[i]) b[i] = 8'($urandom);
    if (!noise) begin
      for (int k = 0; k < MAX_KEYS; k++) begin
        if (run_left[k] == 0) begin
          key_level[k] = ~key_level[k];
          run_left[k]  = run_length(key_level[k], wide);
        end
        run_left[k]--;
        // keys 0 and 1 stay put so both counters saturate
        if (wide && k < 2) key_level[k] = (k == 0);
        bus = k / 8;
        bno = k % 8;
        b[bno & 3][(bno < 4) ? bus : bus + 4] = key_level[k];
      end
    end
    send_scan(b[0], b[1], b[2], b[3]);
  endtask

  task automatic run_items(input idle_mix_t mix, input int n, input bit wide);
    case (mix)
      MIX_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      MIX_SENDER:   begin send_idle_pct = 53; recv_stall_pct = 0;  end
      MIX_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default:      begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && !wide) wait_drained();
      gesture_scan(wide, !wide && ($urandom_range(99) < 15));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_scan_byte_0 = '0;
    in_scan_byte_1 = '0;
    in_scan_byte_2 = '0;
    in_scan_byte_3 = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_press      = 10;
    cur_wait       = 10;
    foreach (key_level[k]) begin
      key_level[k] = 1'b0;
      run_left[k]  = 0;
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset settings, then every gesture on all keys at once
    send_level(1'b0);
    send_level(1'b1);
    configure(24, 2, 2);
    for (int i = 17; i >= 0; i--) send_level(DIRECTED_SEQ[i]);
    configure(0, 0, 0);
    send_level(1'b1);
    configure(31, 0, 0);
    send_level(1'b1);
    send_level(1'b0);

    configure(24, $urandom_range(4, 2), $urandom_range(4, 2));
    run_items(MIX_NONE, 24, 0);
    configure($urandom_range(23, 1), $urandom_range(4, 1), $urandom_range(4, 1));
    run_items(MIX_SENDER, 24, 0);
    configure(24, 1, 3);
    run_items(MIX_RECEIVER, 24, 0);
    configure($urandom_range(24, 1), 3, 1);
    run_items(MIX_BOTH, 24, 0);
    configure(24, $urandom_range(5, 2), $urandom_range(5, 2));
    run_items(MIX_NONE, 24, 0);

    configure(24, 255, 255);
    run_items(MIX_NONE, 64, 1);
    run_items(MIX_SENDER, 64, 1);
    run_items(MIX_RECEIVER, 64, 1);
    run_items(MIX_BOTH, 64, 1);

    wait_drained();
    repeat (40) @(negedge clk);

    $display("covered %0d scans, %0d results: %0d clicks, %0d double clicks, %0d holds, %0d double holds",
             sb.scans, sb.results, sb.act_seen[ACT_CLICK], sb.act_seen[ACT_DOUBLE_CLICK],
             sb.act_seen[ACT_HOLD], sb.act_seen[ACT_DOUBLE_HOLD]);
    $display("key counts 0 to 31, thresholds 0 to 255 with counter saturation, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[keypad_gesture_classifier] OK");
    end else begin
      $display("[keypad_gesture_classifier] ERROR");
    end
    $finish;
  end

endmodule
